>>> src/wsdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants for the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SIZE_W = 64;
    localparam int unsigned KEY_W  = 32;

    // 7-bit length codes that announce an extended length field
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] OPC_CLOSE = 4'h8;

    typedef enum logic [1:0] {
        ST_RUN        = 2'd0,
        ST_DATA_DONE  = 2'd1,
        ST_CLOSE_DONE = 2'd2,
        ST_INCOMPLETE = 2'd3
    } t_status;

endpackage : wsdf_pkg

>>> src/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses one websocket frame per receive buffer, one byte per request, and
// emits unmasked payload bytes together with frame header and status.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock and can sustain that rate
// indefinitely as long as the result side keeps up. Each byte is captured in
// an input register, runs through one pass of header/payload decode logic and
// lands in a result register; a result is presented from the result register
// once its byte has left the input register and the result register is free.
// The longest path is the 64-bit frame size add with saturation
// in the decode stage. Bytes that produce no result (most header bytes and
// the bytes skipped after a finished frame) never occupy the result register,
// and o_in_ready only drops when a result is waiting and i_out_ready is low.
module websocket_frame_deframer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_buffer_end,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_data_byte,
    output logic                  o_data_valid,
    output wsdf_pkg::t_status     o_frame_status,
    output logic                  o_fin_flag,
    output logic [3:0]            o_frame_opcode,
    output logic                  o_masked_flag,
    output logic [63:0]           o_payload_size,
    output logic [63:0]           o_frame_size
);
    import wsdf_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SKIP    = 3'd5
    } t_phase;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;

    // parser state
    t_phase            r_phase,      n_phase;
    logic [2:0]        r_field_cnt,  n_field_cnt;
    logic [3:0]        r_hdr_bytes,  n_hdr_bytes;
    logic              r_fin,        n_fin;
    logic [3:0]        r_opcode,     n_opcode;
    logic              r_masked,     n_masked;
    logic [SIZE_W-1:0] r_length,     n_length;
    logic [SIZE_W-1:0] r_bytes_left, n_bytes_left;
    logic [KEY_W-1:0]  r_mask_key,   n_mask_key;
    logic [1:0]        r_mask_idx,   n_mask_idx;

    // result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_dvalid;
    t_status           r_out_status;
    logic              r_out_fin;
    logic [3:0]        r_out_opcode;
    logic              r_out_masked;
    logic [SIZE_W-1:0] r_out_psize;
    logic [SIZE_W-1:0] r_out_fsize;

    logic [BYTE_W-1:0] n_data;
    logic              n_dvalid;
    t_status           n_status;
    logic              n_produce;
    logic [SIZE_W:0]   n_fsum;
    logic [SIZE_W-1:0] n_fsize;
    logic [BYTE_W-1:0] key_byte;
    logic              advance;

    always_comb begin
        n_phase      = r_phase;
        n_field_cnt  = r_field_cnt;
        n_hdr_bytes  = r_hdr_bytes;
        n_fin        = r_fin;
        n_opcode     = r_opcode;
        n_masked     = r_masked;
        n_length     = r_length;
        n_bytes_left = r_bytes_left;
        n_mask_key   = r_mask_key;
        n_mask_idx   = r_mask_idx;
        n_data       = '0;
        n_dvalid     = 1'b0;
        n_status     = ST_RUN;

        case (r_mask_idx)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase

        case (r_phase)
            PH_HDR1: begin
                n_hdr_bytes = 4'd2;
                n_masked    = r_in_byte[7];
                if (r_in_byte[6:0] == LEN_EXT16) begin
                    n_field_cnt = 3'd1;
                    n_phase     = PH_EXT;
                end else if (r_in_byte[6:0] == LEN_EXT64) begin
                    n_field_cnt = 3'd7;
                    n_phase     = PH_EXT;
                end else begin
                    n_length = {{(SIZE_W-7){1'b0}}, r_in_byte[6:0]};
                    if (n_masked) begin
                        n_phase     = PH_MASK;
                        n_field_cnt = 3'd3;
                    end else begin
                        n_bytes_left = n_length;
                        n_phase      = PH_PAYLOAD;
                    end
                end
            end
            PH_EXT: begin
                n_hdr_bytes = r_hdr_bytes + 4'd1;
                n_length    = {r_length[SIZE_W-BYTE_W-1:0], r_in_byte};
                if (r_field_cnt == 3'd0) begin
                    if (r_masked) begin
                        n_phase     = PH_MASK;
                        n_field_cnt = 3'd3;
                    end else begin
                        n_bytes_left = n_length;
                        n_phase      = PH_PAYLOAD;
                    end
                end else begin
                    n_field_cnt = r_field_cnt - 3'd1;
                end
            end
            PH_MASK: begin
                n_hdr_bytes = r_hdr_bytes + 4'd1;
                n_mask_key  = {r_mask_key[KEY_W-BYTE_W-1:0], r_in_byte};
                if (r_field_cnt == 3'd0) begin
                    n_bytes_left = r_length;
                    n_phase      = PH_PAYLOAD;
                end else begin
                    n_field_cnt = r_field_cnt - 3'd1;
                end
            end
            PH_PAYLOAD: begin
                if (r_bytes_left != '0) begin
                    n_data       = r_in_byte ^ key_byte;
                    n_dvalid     = 1'b1;
                    n_mask_idx   = r_mask_idx + 2'd1;
                    n_bytes_left = r_bytes_left - 64'd1;
                end
            end
            PH_SKIP: begin
            end
            default: begin
                // first header byte, also taken for unused phase codes
                n_fin        = r_in_byte[7];
                n_opcode     = r_in_byte[3:0];
                n_masked     = 1'b0;
                n_length     = '0;
                n_bytes_left = '0;
                n_mask_key   = '0;
                n_mask_idx   = 2'd0;
                n_field_cnt  = 3'd0;
                n_hdr_bytes  = 4'd1;
                n_phase      = PH_HDR1;
            end
        endcase

        if (r_phase == PH_SKIP) begin
            if (r_in_end) begin
                n_phase = PH_HDR0;
            end
        end else if (n_phase == PH_PAYLOAD && n_bytes_left == '0) begin
            n_status = (n_opcode == OPC_CLOSE) ? ST_CLOSE_DONE : ST_DATA_DONE;
            n_phase  = r_in_end ? PH_HDR0 : PH_SKIP;
        end else if (r_in_end) begin
            n_status = ST_INCOMPLETE;
            n_phase  = PH_HDR0;
        end

        n_produce = n_dvalid || (n_status != ST_RUN);

        // frame size saturates on carry out
        n_fsum  = {1'b0, n_length} + {{(SIZE_W-3){1'b0}}, n_hdr_bytes};
        n_fsize = n_fsum[SIZE_W] ? {SIZE_W{1'b1}} : n_fsum[SIZE_W-1:0];
    end

    assign advance    = r_in_valid && (!n_produce || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_HDR0;
            r_field_cnt  <= '0;
            r_hdr_bytes  <= '0;
            r_fin        <= 1'b0;
            r_opcode     <= '0;
            r_masked     <= 1'b0;
            r_length     <= '0;
            r_bytes_left <= '0;
            r_mask_key   <= '0;
            r_mask_idx   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_phase      <= n_phase;
                r_field_cnt  <= n_field_cnt;
                r_hdr_bytes  <= n_hdr_bytes;
                r_fin        <= n_fin;
                r_opcode     <= n_opcode;
                r_masked     <= n_masked;
                r_length     <= n_length;
                r_bytes_left <= n_bytes_left;
                r_mask_key   <= n_mask_key;
                r_mask_idx   <= n_mask_idx;
            end
            if (advance && n_produce) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_end  <= i_buffer_end;
        end
        if (advance && n_produce) begin
            r_out_data   <= n_data;
            r_out_dvalid <= n_dvalid;
            r_out_status <= n_status;
            r_out_fin    <= n_fin;
            r_out_opcode <= n_opcode;
            r_out_masked <= n_masked;
            r_out_psize  <= n_length;
            r_out_fsize  <= n_fsize;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_byte    = r_out_data;
    assign o_data_valid   = r_out_dvalid;
    assign o_frame_status = r_out_status;
    assign o_fin_flag     = r_out_fin;
    assign o_frame_opcode = r_out_opcode;
    assign o_masked_flag  = r_out_masked;
    assign o_payload_size = r_out_psize;
    assign o_frame_size   = r_out_fsize;

    // a delivered result always carries a payload byte or a status
    a_result_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_data_valid || o_frame_status != ST_RUN))
        else $error("result without payload or status");

    // bytes after a finished frame never produce a result
    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_phase == PH_SKIP) |-> !n_produce)
        else $error("skipped byte produced a result");

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_produce) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // masking key counter stays within four bytes
    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MASK) |-> (r_field_cnt <= 3'd3))
        else $error("mask byte count out of range");

    // payload bytes are counted down one per emitted byte
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_dvalid) |=> (r_bytes_left == $past(r_bytes_left) - 64'd1))
        else $error("payload count not decremented");

endmodule : websocket_frame_deframer
